// ===== rtl/hcbd_pkg.sv =====
// Package for the chunked body decoder: payload structs, decode phases,
// status codes and character helpers. No dependencies.
`default_nettype none

package hcbd_pkg;

	localparam int SIZE_BITS = 32;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_DIGITS = 3'd1,
		PH_TAIL   = 3'd2,
		PH_CR     = 3'd3,
		PH_DATA   = 3'd4,
		PH_TRAIL1 = 3'd5,
		PH_TRAIL2 = 3'd6,
		PH_HALT   = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		ST_CLEAN    = 2'd0,
		ST_NOFINAL  = 2'd1,
		ST_NODIGITS = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       body_end;
	} body_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       done_res;
		logic [1:0] end_status;
	} result_t;

	// bit 4 flags a hex digit, bits 3:0 carry its value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, 4'(c[2:0] + 3'd1) + 4'd8};
		end
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/http_chunked_body_decoder.sv =====
// Chunked transfer decoder for an HTTP body stream, one byte per request.
// Depends on hcbd_pkg for payload structs, phases and status codes.
//
// Usage:
//   body channel (body_valid/body_ready/body) carries raw body bytes, with
//   body_end set on the final byte. res channel (res_valid/res_ready/res)
//   carries a result for every payload byte and for the final body byte;
//   size lines, trailer bytes and bytes after the end chunk give none.
//   A body byte passes from the input register through the decode logic into
//   the result register, which raises res_valid. Throughput is one byte per
//   clock while res is not stalled, as the phase and size counter update for
//   every accepted byte.
//   When res is stalled, bytes that give no result still drain; a byte that
//   gives a result waits in the input register and body_ready drops.
//   The final byte returns the decoder to the size-line state for the next
//   body. Reset (arst_n low) clears both valid flags and the decode state.
`default_nettype none

module http_chunked_body_decoder (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   body_valid,
	output logic                  body_ready,
	input  hcbd_pkg::body_t       body,
	output logic                  res_valid,
	input  wire                   res_ready,
	output hcbd_pkg::result_t     res
);
	import hcbd_pkg::*;

	logic                 valid_s1;
	body_t                body_s1;
	phase_t               phase_q, phase_d;
	logic [SIZE_BITS-1:0] left_q, left_d;
	logic                 seen_q, seen_d;
	status_t              held_q, held_d;
	logic                 emit;
	logic                 produce;
	logic                 advance;
	logic                 run_line;
	phase_t               line_from;
	logic [4:0]           hex;
	result_t              res_d;

	assign produce    = emit || body_s1.body_end;
	assign advance    = valid_s1 && (!produce || !res_valid || res_ready);
	assign body_ready = !valid_s1 || advance;
	assign hex        = hex_digit(body_s1.body_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body_ready) begin
			valid_s1 <= body_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body_ready && body_valid) begin
			body_s1 <= body;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		seen_d    = seen_q;
		held_d    = held_q;
		emit      = 1'b0;
		run_line  = 1'b0;
		line_from = phase_q;
		unique case (phase_q)
			PH_LEAD, PH_DIGITS, PH_TAIL: begin
				run_line = 1'b1;
			end
			PH_CR: begin
				if (body_s1.body_byte == CHAR_LF) begin
					if (!seen_q) begin
						phase_d = PH_HALT;
						held_d  = ST_NODIGITS;
					end else if (left_q == '0) begin
						phase_d = PH_HALT;
						held_d  = ST_CLEAN;
					end else begin
						phase_d = PH_DATA;
					end
				end else begin
					run_line  = 1'b1;
					line_from = seen_q ? PH_TAIL : PH_LEAD;
				end
			end
			PH_DATA: begin
				emit   = 1'b1;
				left_d = left_q - 1'b1;
				if (left_d == '0) begin
					phase_d = PH_TRAIL1;
				end
			end
			PH_TRAIL1: begin
				phase_d = PH_TRAIL2;
			end
			PH_TRAIL2: begin
				phase_d = PH_LEAD;
				left_d  = '0;
				seen_d  = 1'b0;
			end
			PH_HALT: begin
			end
		endcase
		if (run_line) begin
			priority if (body_s1.body_byte == CHAR_CR) begin
				phase_d = PH_CR;
			end else if (line_from == PH_LEAD && is_space(body_s1.body_byte)) begin
				phase_d = PH_LEAD;
			end else if (line_from == PH_LEAD || line_from == PH_DIGITS) begin
				if (!hex[4]) begin
					phase_d = PH_TAIL;
				end else if (left_q[SIZE_BITS-1 -: 4] != 4'd0) begin
					phase_d = PH_HALT;
					held_d  = ST_OVERFLOW;
				end else begin
					phase_d = PH_DIGITS;
					left_d  = {left_q[SIZE_BITS-5:0], hex[3:0]};
					seen_d  = 1'b1;
				end
			end else begin
				phase_d = PH_TAIL;
			end
		end
	end

	always_comb begin
		res_d            = '0;
		res_d.data_byte  = emit ? body_s1.body_byte : 8'd0;
		res_d.has_byte   = emit;
		res_d.done_res   = body_s1.body_end;
		if (body_s1.body_end) begin
			res_d.end_status = (phase_d == PH_HALT) ? held_d : ST_NOFINAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			left_q  <= '0;
			seen_q  <= 1'b0;
			held_q  <= ST_CLEAN;
		end else if (advance) begin
			if (body_s1.body_end) begin
				phase_q <= PH_LEAD;
				left_q  <= '0;
				seen_q  <= 1'b0;
				held_q  <= ST_CLEAN;
			end else begin
				phase_q <= phase_d;
				left_q  <= left_d;
				seen_q  <= seen_d;
				held_q  <= held_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance && produce) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			res <= res_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_nobyte_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.has_byte |-> res.done_res)
		else $error("result without payload byte is not final");

	a_status_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.done_res |-> res.end_status == ST_CLEAN)
		else $error("status set on a non-final result");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && body_s1.body_end |=> phase_q == PH_LEAD && left_q == '0 && !seen_q)
		else $error("decoder not back in size-line state after final byte");

	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("data phase with no bytes left");
`endif

endmodule

`default_nettype wire
